@@ hdl/srtf_pkg.sv @@
// Shared types and constants for the SRTF tick scheduler.
// Holds the beat structs, command codes and default sizes; no dependencies.
package srtf_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    localparam int          TICK_W   = 21;
    localparam logic [20:0] TICK_MAX = 21'h1FFFFF;
    localparam int          CFG_W    = 5;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  entry_index;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
    } t_in_beat;

    typedef struct packed {
        logic        ran;
        logic [3:0]  run_index;
        logic        finished;
        logic [20:0] completion_tick;
        logic [20:0] turnaround;
        logic [20:0] waiting;
        logic        all_done;
    } t_out_beat;

    typedef struct packed {
        logic ab_we;
        logic rem_we;
        logic rem_arm;
    } t_mem_ctl;

endpackage

@@ hdl/srtf_tick_scheduler.sv @@
// Flow: load and unknown commands go straight to the report state; restart sweeps every
// slot, and tick scans the active slots, then updates, forms turnaround and waiting, and reports.
// One item at a time; the next beat is taken the cycle after the result is registered.
// Reset (synchronous, i_rst_n low): clock and done count to zero, count register
// to one, remaining times read as zero until the first restart; no clearing pass.
module srtf_tick_scheduler #(
    parameter int MAX_TASKS = srtf_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  srtf_pkg::t_in_beat         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output srtf_pkg::t_out_beat        o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [srtf_pkg::CFG_W-1:0] i_cfg_data
);
    import srtf_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);

    // Configuration: process count, always ready for a beat.
    logic [CFG_W-1:0] r_proc_count;

    // Result register: decouples the output side so a new beat is taken
    // while the previous result still waits for the consumer.
    logic      r_out_valid;
    t_out_beat r_out_data;

    logic      start;
    logic      idle;
    logic      res_valid;
    logic      res_room;
    t_out_beat res;
    t_mem_ctl  mem;

    logic [IDX_W-1:0]     ab_addr;
    logic [TIME_BITS-1:0] ab_arr;
    logic [TIME_BITS-1:0] ab_bur;
    logic [IDX_W-1:0]     rem_addr;
    logic [TIME_BITS-1:0] rem_data;
    logic [IDX_W-1:0]     rd_addr;
    logic [TIME_BITS-1:0] rd_arr;
    logic [TIME_BITS-1:0] rd_bur;
    logic [TIME_BITS-1:0] rd_rem;

    logic                 scan_clear;
    logic                 scan_vld;
    logic [IDX_W-1:0]     scan_idx;
    logic [TICK_W-1:0]    tick;
    logic                 best_found;
    logic [IDX_W-1:0]     best_idx;
    logic [TIME_BITS-1:0] best_arr;
    logic [TIME_BITS-1:0] best_bur;
    logic [TIME_BITS-1:0] best_rem;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = idle;
    assign start       = i_in_valid && idle;
    assign res_room    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_count <= CFG_W'(1);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_proc_count <= i_cfg_data;
            end
            // load a fresh result, or drop the one just taken
            if (res_valid) begin
                r_out_valid <= 1'b1;
                r_out_data  <= res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    srtf_ctrl #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_item       (i_in_data),
        .i_proc_count (r_proc_count),
        .i_res_room   (res_room),
        .o_idle       (idle),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_mem        (mem),
        .o_ab_addr    (ab_addr),
        .o_ab_arr     (ab_arr),
        .o_ab_bur     (ab_bur),
        .o_rem_addr   (rem_addr),
        .o_rem_data   (rem_data),
        .o_rd_addr    (rd_addr),
        .i_rd_bur     (rd_bur),
        .o_scan_clear (scan_clear),
        .o_scan_vld   (scan_vld),
        .o_scan_idx   (scan_idx),
        .o_tick       (tick),
        .i_best_found (best_found),
        .i_best_idx   (best_idx),
        .i_best_arr   (best_arr),
        .i_best_bur   (best_bur),
        .i_best_rem   (best_rem)
    );

    srtf_store #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mem      (mem),
        .i_ab_addr  (ab_addr),
        .i_ab_arr   (ab_arr),
        .i_ab_bur   (ab_bur),
        .i_rem_addr (rem_addr),
        .i_rem_data (rem_data),
        .i_rd_addr  (rd_addr),
        .o_rd_arr   (rd_arr),
        .o_rd_bur   (rd_bur),
        .o_rd_rem   (rd_rem)
    );

    srtf_scan #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (scan_clear),
        .i_vld   (scan_vld),
        .i_idx   (scan_idx),
        .i_arr   (rd_arr),
        .i_bur   (rd_bur),
        .i_rem   (rd_rem),
        .i_tick  (tick),
        .o_found (best_found),
        .o_idx   (best_idx),
        .o_arr   (best_arr),
        .o_bur   (best_bur),
        .o_rem   (best_rem)
    );

endmodule

@@ hdl/srtf_store.sv @@
// Task store: arrival/burst memory and remaining-time memory, one read port.
// Depends on srtf_pkg for the memory control struct.
module srtf_store #(
    parameter int MAX_TASKS = srtf_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  srtf_pkg::t_mem_ctl           i_mem,
    input  logic [$clog2(MAX_TASKS)-1:0] i_ab_addr,
    input  logic [TIME_BITS-1:0]         i_ab_arr,
    input  logic [TIME_BITS-1:0]         i_ab_bur,
    input  logic [$clog2(MAX_TASKS)-1:0] i_rem_addr,
    input  logic [TIME_BITS-1:0]         i_rem_data,
    input  logic [$clog2(MAX_TASKS)-1:0] i_rd_addr,
    output logic [TIME_BITS-1:0]         o_rd_arr,
    output logic [TIME_BITS-1:0]         o_rd_bur,
    output logic [TIME_BITS-1:0]         o_rd_rem
);
    import srtf_pkg::*;

    logic [2*TIME_BITS-1:0] r_ab_mem  [MAX_TASKS];
    logic [TIME_BITS-1:0]   r_rem_mem [MAX_TASKS];
    logic [2*TIME_BITS-1:0] r_rd_ab;
    logic [TIME_BITS-1:0]   r_rd_rem;
    logic                   r_live;
    logic                   r_rd_live;

    always_ff @(posedge i_clk) begin
        if (i_mem.ab_we) begin
            r_ab_mem[i_ab_addr] <= {i_ab_arr, i_ab_bur};
        end
        if (i_mem.rem_we) begin
            r_rem_mem[i_rem_addr] <= i_rem_data;
        end
        r_rd_ab  <= r_ab_mem[i_rd_addr];
        r_rd_rem <= r_rem_mem[i_rd_addr];
    end

    // remaining times read as zero until the first restart sweep fills them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= 1'b0;
            r_rd_live <= 1'b0;
        end else begin
            if (i_mem.rem_arm) begin
                r_live <= 1'b1;
            end
            r_rd_live <= r_live;
        end
    end

    assign o_rd_arr = r_rd_ab[2*TIME_BITS-1:TIME_BITS];
    assign o_rd_bur = r_rd_ab[TIME_BITS-1:0];
    assign o_rd_rem = r_rd_live ? r_rd_rem : '0;

endmodule

@@ hdl/srtf_scan.sv @@
// Running-minimum unit: keeps the best ready task seen during a table scan.
// Depends on srtf_pkg for the tick width.
module srtf_scan #(
    parameter int MAX_TASKS = srtf_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_vld,
    input  logic [$clog2(MAX_TASKS)-1:0] i_idx,
    input  logic [TIME_BITS-1:0]         i_arr,
    input  logic [TIME_BITS-1:0]         i_bur,
    input  logic [TIME_BITS-1:0]         i_rem,
    input  logic [srtf_pkg::TICK_W-1:0]  i_tick,
    output logic                         o_found,
    output logic [$clog2(MAX_TASKS)-1:0] o_idx,
    output logic [TIME_BITS-1:0]         o_arr,
    output logic [TIME_BITS-1:0]         o_bur,
    output logic [TIME_BITS-1:0]         o_rem
);
    import srtf_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CW    = (TIME_BITS > TICK_W) ? TIME_BITS : TICK_W;

    logic             r_found;
    logic [IDX_W-1:0] r_idx;
    logic [TIME_BITS-1:0] r_arr;
    logic [TIME_BITS-1:0] r_bur;
    logic [TIME_BITS-1:0] r_rem;
    logic             ready_now;
    logic             take;

    // strict less-than keeps the lowest index on a tie
    assign ready_now = (CW'(i_arr) <= CW'(i_tick)) && (i_rem != '0);
    assign take      = i_vld && ready_now && (!r_found || (i_rem < r_rem));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
            r_idx   <= i_idx;
            r_arr   <= i_arr;
            r_bur   <= i_bur;
            r_rem   <= i_rem;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_arr   = r_arr;
    assign o_bur   = r_bur;
    assign o_rem   = r_rem;

endmodule

@@ hdl/srtf_ctrl.sv @@
// Sequencer: load, restart sweep, scan, write-back, turnaround, waiting and report stages.
// Depends on srtf_pkg; drives srtf_store and srtf_scan.
module srtf_ctrl #(
    parameter int MAX_TASKS = srtf_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  srtf_pkg::t_in_beat           i_item,
    input  logic [srtf_pkg::CFG_W-1:0]   i_proc_count,
    input  logic                         i_res_room,
    output logic                         o_idle,
    output logic                         o_res_valid,
    output srtf_pkg::t_out_beat          o_res,
    output srtf_pkg::t_mem_ctl           o_mem,
    output logic [$clog2(MAX_TASKS)-1:0] o_ab_addr,
    output logic [TIME_BITS-1:0]         o_ab_arr,
    output logic [TIME_BITS-1:0]         o_ab_bur,
    output logic [$clog2(MAX_TASKS)-1:0] o_rem_addr,
    output logic [TIME_BITS-1:0]         o_rem_data,
    output logic [$clog2(MAX_TASKS)-1:0] o_rd_addr,
    input  logic [TIME_BITS-1:0]         i_rd_bur,
    output logic                         o_scan_clear,
    output logic                         o_scan_vld,
    output logic [$clog2(MAX_TASKS)-1:0] o_scan_idx,
    output logic [srtf_pkg::TICK_W-1:0]  o_tick,
    input  logic                         i_best_found,
    input  logic [$clog2(MAX_TASKS)-1:0] i_best_idx,
    input  logic [TIME_BITS-1:0]         i_best_arr,
    input  logic [TIME_BITS-1:0]         i_best_bur,
    input  logic [TIME_BITS-1:0]         i_best_rem
);
    import srtf_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int CW    = (TIME_BITS > TICK_W) ? TIME_BITS : TICK_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RSTW,
        S_SCAN,
        S_UPD,
        S_TAT,
        S_WT,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_addr;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [TICK_W-1:0] r_tick;
    logic [CNT_W-1:0]  r_done;
    logic              r_ran;
    logic [3:0]        r_run_idx;
    logic              r_fin;
    logic [TICK_W-1:0] r_comp;
    logic [TICK_W-1:0] r_tat;
    logic [TICK_W-1:0] r_wt;

    logic [CNT_W-1:0]  cnt;
    logic              issue;
    logic              rd_counted;

    // take a 16-bit time field in the low TIME_BITS bits
    function automatic logic [TIME_BITS-1:0] to_time(input logic [15:0] v);
        logic [TIME_BITS+15:0] t;
        t = {{TIME_BITS{1'b0}}, v};
        return t[TIME_BITS-1:0];
    endfunction

    // entry index modulo the table size, by repeated subtraction
    function automatic logic [IDX_W-1:0] slot_of(input logic [3:0] v);
        logic [7:0] s;
        s = {4'b0, v};
        for (int k = 0; k < 8; k++) begin
            if (s >= 8'(MAX_TASKS)) begin
                s = s - 8'(MAX_TASKS);
            end
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [3:0] idx4(input logic [IDX_W-1:0] v);
        logic [IDX_W+3:0] t;
        t = {4'b0, v};
        return t[3:0];
    endfunction

    always_comb begin
        if (8'(i_proc_count) > 8'(MAX_TASKS)) begin
            cnt = CNT_W'(MAX_TASKS);
        end else begin
            cnt = CNT_W'(i_proc_count);
        end
    end

    assign issue = ((r_state == S_SCAN) && (r_addr < cnt)) ||
                   ((r_state == S_RSTW) && (r_addr < CNT_W'(MAX_TASKS)));
    assign rd_counted = CNT_W'(r_rd_idx) < cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_tick   <= '0;
            r_done   <= '0;
        end else begin
            r_rd_vld <= issue;
            r_rd_idx <= r_addr[IDX_W-1:0];
            if (issue) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_ran     <= 1'b0;
                        r_run_idx <= '0;
                        r_fin     <= 1'b0;
                        r_comp    <= '0;
                        r_tat     <= '0;
                        r_wt      <= '0;
                        r_addr    <= '0;
                        case (i_item.command)
                            CMD_TICK: begin
                                r_state <= S_SCAN;
                            end
                            CMD_RESTART: begin
                                r_tick  <= '0;
                                r_done  <= '0;
                                r_state <= S_RSTW;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RSTW: begin
                    if (r_rd_vld && rd_counted && (i_rd_bur == '0)) begin
                        r_done <= r_done + CNT_W'(1);
                    end
                    if (!issue && !r_rd_vld) begin
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (!issue && !r_rd_vld) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (i_best_found) begin
                        r_ran     <= 1'b1;
                        r_run_idx <= idx4(i_best_idx);
                        if (i_best_rem == TIME_BITS'(1)) begin
                            r_fin  <= 1'b1;
                            r_done <= r_done + CNT_W'(1);
                            r_comp <= (r_tick == TICK_MAX) ? TICK_MAX
                                                           : r_tick + TICK_W'(1);
                        end
                    end
                    if (r_tick != TICK_MAX) begin
                        r_tick <= r_tick + TICK_W'(1);
                    end
                    r_state <= S_TAT;
                end
                S_TAT: begin
                    if (r_fin && (CW'(r_comp) >= CW'(i_best_arr))) begin
                        r_tat <= TICK_W'(CW'(r_comp) - CW'(i_best_arr));
                    end
                    r_state <= S_WT;
                end
                S_WT: begin
                    if (r_fin && (CW'(r_tat) >= CW'(i_best_bur))) begin
                        r_wt <= TICK_W'(CW'(r_tat) - CW'(i_best_bur));
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_room) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_mem.ab_we   = (r_state == S_IDLE) && i_start && (i_item.command == CMD_LOAD);
        o_mem.rem_arm = (r_state == S_IDLE) && i_start && (i_item.command == CMD_RESTART);
        o_mem.rem_we  = 1'b0;
        o_rem_addr    = r_rd_idx;
        o_rem_data    = '0;
        if ((r_state == S_RSTW) && r_rd_vld) begin
            o_mem.rem_we = 1'b1;
            o_rem_data   = rd_counted ? i_rd_bur : '0;
        end else if ((r_state == S_UPD) && i_best_found) begin
            o_mem.rem_we = 1'b1;
            o_rem_addr   = i_best_idx;
            o_rem_data   = i_best_rem - TIME_BITS'(1);
        end
    end

    assign o_ab_addr    = slot_of(i_item.entry_index);
    assign o_ab_arr     = to_time(i_item.arrival_time);
    assign o_ab_bur     = to_time(i_item.burst_time);
    assign o_rd_addr    = r_addr[IDX_W-1:0];
    assign o_scan_clear = (r_state == S_IDLE) && i_start;
    assign o_scan_vld   = (r_state == S_SCAN) && r_rd_vld;
    assign o_scan_idx   = r_rd_idx;
    assign o_tick       = r_tick;

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE) && i_res_room;

    always_comb begin
        o_res.ran             = r_ran;
        o_res.run_index       = r_run_idx;
        o_res.finished        = r_fin;
        o_res.completion_tick = r_comp;
        o_res.turnaround      = r_tat;
        o_res.waiting         = r_wt;
        o_res.all_done        = (r_done >= cnt);
    end

endmodule

@@ hdl/srtf_checker.sv @@
// Port-level checks for the SRTF tick scheduler, attached by bind.
// Depends on srtf_pkg for the result beat type.
module srtf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input srtf_pkg::t_out_beat o_out_data
);
    import srtf_pkg::*;

    // no result beat straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    a_fin_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.finished |-> o_out_data.ran)
        else $error("completion reported without a served task");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.ran |->
            o_out_data.run_index == 4'd0 && o_out_data.completion_tick == 21'd0 &&
            o_out_data.turnaround == 21'd0 && o_out_data.waiting == 21'd0)
        else $error("idle beat carries non-zero fields");

    a_times_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.finished |->
            o_out_data.completion_tick != 21'd0 &&
            o_out_data.turnaround <= o_out_data.completion_tick &&
            o_out_data.waiting <= o_out_data.turnaround)
        else $error("completion times out of order");

endmodule

bind srtf_tick_scheduler srtf_checker u_srtf_checker (.*);
